// ===== rtl/mlm_pkg.sv =====
// Package for the mutex lock manager: request kinds, status codes, entry types.
// No dependencies.
package mlm_pkg;

    localparam int KIND_W = 2;
    localparam int ID_W   = 4;
    localparam int ST_W   = 4;

    localparam logic [KIND_W-1:0] K_LOCK    = 2'd0;
    localparam logic [KIND_W-1:0] K_UNLOCK  = 2'd1;
    localparam logic [KIND_W-1:0] K_INIT    = 2'd2;
    localparam logic [KIND_W-1:0] K_DESTROY = 2'd3;

    localparam logic [ST_W-1:0] ST_GRANTED  = 4'd0;
    localparam logic [ST_W-1:0] ST_QUEUED   = 4'd1;
    localparam logic [ST_W-1:0] ST_RELEASED = 4'd2;
    localparam logic [ST_W-1:0] ST_HANDOVER = 4'd3;
    localparam logic [ST_W-1:0] ST_UNINIT   = 4'd4;
    localparam logic [ST_W-1:0] ST_DEADLOCK = 4'd5;
    localparam logic [ST_W-1:0] ST_NOTOWNER = 4'd6;
    localparam logic [ST_W-1:0] ST_INUSE    = 4'd7;
    localparam logic [ST_W-1:0] ST_WAITING  = 4'd8;

    // Lock table entry.
    typedef struct packed {
        logic            ready;
        logic            held;
        logic [ID_W-1:0] owner;
        logic            hd_v;
        logic [ID_W-1:0] head;
        logic            tl_v;
        logic [ID_W-1:0] tail;
    } t_lock_ent;

    // Thread table entry.
    typedef struct packed {
        logic            wait_v;
        logic [ID_W-1:0] wait_lk;
        logic            nxt_v;
        logic [ID_W-1:0] nxt;
    } t_thr_ent;

    typedef struct packed {
        logic [ST_W-1:0] status;
        logic            woken_valid;
        logic [ID_W-1:0] woken_thread;
    } t_result;

endpackage

// ===== rtl/mlm_if.sv =====
// Valid/ready channel interfaces for requests and results.
// Depends on mlm_pkg.
interface mlm_req_if;
    logic                      valid;
    logic                      ready;
    logic [mlm_pkg::KIND_W-1:0] kind;
    logic [mlm_pkg::ID_W-1:0]   caller;
    logic [mlm_pkg::ID_W-1:0]   lock_id;
    modport source (output valid, kind, caller, lock_id, input ready);
    modport sink (input valid, kind, caller, lock_id, output ready);
endinterface

interface mlm_rsp_if;
    logic                     valid;
    logic                     ready;
    logic [mlm_pkg::ST_W-1:0] status;
    logic                     woken_valid;
    logic [mlm_pkg::ID_W-1:0] woken_thread;
    modport source (output valid, status, woken_valid, woken_thread, input ready);
    modport sink (input valid, status, woken_valid, woken_thread, output ready);
endinterface

// ===== rtl/mutex_lock_manager_deadlock_check.sv =====
// Top level of the mutex lock manager with wait-for cycle detection.
// Depends on mlm_pkg and the channel interfaces in mlm_if.sv.
//
// One request is handled at a time. A request transfer is taken in S_IDLE;
// S_RD reads the lock entry and the caller's thread entry from two
// synchronous tables (registered read data) and S_DEC decides. A lock request
// on a held lock with error checking on walks the wait-for chain through
// S_WT (test owner), S_WL (read its thread entry) and S_WO (read the
// awaited lock), for at most NUM_THREADS owners plus one final check in S_WT.
// A handover passes through S_HEAD to read the head thread's entry. S_WB
// writes the lock entry and, where needed, one thread entry; joining a
// non-empty queue adds S_LINK to link the old tail. S_OUT loads the result
// into the output register and holds while an earlier result there is not
// yet taken. Out-of-range ids go from S_RD straight to S_OUT, and refusals
// found at decode go from S_DEC to S_OUT. Valid bits beside each table make
// unwritten entries read as cleared after reset; no clearing pass is needed.
// Out-of-range ids read as uninitialized.
module mutex_lock_manager_deadlock_check #(
    parameter int NUM_THREADS = 16,
    parameter int NUM_LOCKS   = 16
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_cfg_we,
    input  logic i_cfg_wdata,
    mlm_req_if.sink   i_req,
    mlm_rsp_if.source o_rsp
);
    localparam int ID_W = mlm_pkg::ID_W;
    localparam int TW   = (NUM_THREADS > 1) ? $clog2(NUM_THREADS) : 1;
    localparam int LW   = (NUM_LOCKS > 1) ? $clog2(NUM_LOCKS) : 1;
    localparam int SW   = $clog2(NUM_THREADS + 1);

    typedef enum logic [9:0] {
        S_IDLE  = 10'b00_0000_0001,
        S_RD    = 10'b00_0000_0010,
        S_DEC   = 10'b00_0000_0100,
        S_WT    = 10'b00_0000_1000,
        S_WL    = 10'b00_0001_0000,
        S_WO    = 10'b00_0010_0000,
        S_HEAD  = 10'b00_0100_0000,
        S_WB    = 10'b00_1000_0000,
        S_LINK  = 10'b01_0000_0000,
        S_OUT   = 10'b10_0000_0000
    } t_state;

    t_state r_state, n_state;

    logic r_ec;
    logic [mlm_pkg::KIND_W-1:0] r_kind;
    logic [ID_W-1:0] r_t, r_lk;
    logic r_oor;

    // Memories
    mlm_pkg::t_lock_ent lmem [NUM_LOCKS];
    mlm_pkg::t_thr_ent  tmem [NUM_THREADS];
    logic [NUM_LOCKS-1:0]   r_lval;
    logic [NUM_THREADS-1:0] r_tval;

    // Read ports (registered data)
    logic            lrd_en, trd_en;
    logic [LW-1:0]   lrd_a;
    logic [TW-1:0]   trd_a;
    mlm_pkg::t_lock_ent r_lq;
    mlm_pkg::t_thr_ent  r_tq;
    logic r_lqv, r_tqv;
    mlm_pkg::t_lock_ent lq;
    mlm_pkg::t_thr_ent  tq;

    // Write ports
    logic            lwr_en, twr_en;
    logic [LW-1:0]   lwr_a;
    logic [TW-1:0]   twr_a;
    mlm_pkg::t_lock_ent lwr_d;
    mlm_pkg::t_thr_ent  twr_d;

    // Working copies
    mlm_pkg::t_lock_ent r_le, n_le;
    logic [ID_W-1:0] r_own, n_own;
    logic [SW-1:0]   r_steps, n_steps;
    logic            r_twe, n_twe;
    logic [TW-1:0]   r_twa, n_twa;
    mlm_pkg::t_thr_ent r_twd, n_twd;
    logic            r_link, n_link;
    logic [TW-1:0]   r_linka, n_linka;
    logic            do_enq;
    mlm_pkg::t_result r_res, n_res;
    mlm_pkg::t_result r_out;
    logic r_ovalid;
    logic out_load;

    always_ff @(posedge i_clk) begin
        if (lrd_en) r_lq <= lmem[lrd_a];
        if (trd_en) r_tq <= tmem[trd_a];
        if (lwr_en) lmem[lwr_a] <= lwr_d;
        if (twr_en) tmem[twr_a] <= twr_d;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lval <= '0;
            r_tval <= '0;
            r_lqv  <= 1'b0;
            r_tqv  <= 1'b0;
        end else begin
            if (lrd_en) r_lqv <= r_lval[lrd_a];
            if (trd_en) r_tqv <= r_tval[trd_a];
            if (lwr_en) r_lval[lwr_a] <= 1'b1;
            if (twr_en) r_tval[twr_a] <= 1'b1;
        end
    end

    assign lq = r_lqv ? r_lq : '0;
    assign tq = r_tqv ? r_tq : '0;

    function automatic logic t_ok(input logic [ID_W-1:0] v);
        t_ok = ({{(32-ID_W){1'b0}}, v} < NUM_THREADS);
    endfunction
    function automatic logic l_ok(input logic [ID_W-1:0] v);
        l_ok = ({{(32-ID_W){1'b0}}, v} < NUM_LOCKS);
    endfunction

    // Append a thread at the tail of a lock's queue.
    function automatic mlm_pkg::t_lock_ent enq_ent(input mlm_pkg::t_lock_ent e,
                                                   input logic [ID_W-1:0] thr);
        enq_ent = e;
        if (!e.hd_v) begin
            enq_ent.hd_v = 1'b1;
            enq_ent.head = thr;
        end
        enq_ent.tl_v = 1'b1;
        enq_ent.tail = thr;
    endfunction

    assign i_req.ready = (r_state == S_IDLE);
    assign o_rsp.valid = r_ovalid;
    assign o_rsp.status = r_out.status;
    assign o_rsp.woken_valid = r_out.woken_valid;
    assign o_rsp.woken_thread = r_out.woken_thread;

    // Load the result once the output register is free or drains this cycle.
    assign out_load = (r_state == S_OUT) && (!r_ovalid || o_rsp.ready);

    always_comb begin
        n_state = r_state;
        n_le    = r_le;
        n_own   = r_own;
        n_steps = r_steps;
        n_res   = r_res;
        n_twe   = r_twe;
        n_twa   = r_twa;
        n_twd   = r_twd;
        n_link  = r_link;
        n_linka = r_linka;
        do_enq  = 1'b0;
        lrd_en = 1'b0;
        trd_en = 1'b0;
        lrd_a = LW'(r_lk);
        trd_a = TW'(r_t);
        lwr_en = 1'b0;
        twr_en = 1'b0;
        lwr_a = LW'(r_lk);
        twr_a = r_twa;
        lwr_d = r_le;
        twr_d = r_twd;
        case (r_state)
            S_IDLE: begin
                if (i_req.valid) n_state = S_RD;
            end
            S_RD: begin
                // read lock and caller entries
                if (r_oor) begin
                    n_res = '{mlm_pkg::ST_UNINIT, 1'b0, '0};
                    n_state = S_OUT;
                end else begin
                    lrd_en = 1'b1;
                    trd_en = 1'b1;
                    n_state = S_DEC;
                end
            end
            S_DEC: begin
                n_le = lq;
                n_res = '{mlm_pkg::ST_GRANTED, 1'b0, '0};
                n_twe = 1'b0;
                n_link = 1'b0;
                n_state = S_WB;
                if (tq.wait_v) begin
                    n_res.status = mlm_pkg::ST_WAITING;
                    n_state = S_OUT;
                end else begin
                    case (r_kind)
                        mlm_pkg::K_LOCK: begin
                            if (!lq.ready) begin
                                n_res.status = mlm_pkg::ST_UNINIT;
                                n_state = S_OUT;
                            end else if (!lq.held) begin
                                n_le.held = 1'b1;
                                n_le.owner = r_t;
                            end else if (r_ec) begin
                                // start the walk at the current holder
                                n_own = lq.owner;
                                n_steps = '0;
                                n_state = S_WT;
                            end else begin
                                do_enq = 1'b1;
                            end
                        end
                        mlm_pkg::K_UNLOCK: begin
                            if (!lq.ready) begin
                                n_res.status = mlm_pkg::ST_UNINIT;
                                n_state = S_OUT;
                            end else if (!lq.held || lq.owner != r_t) begin
                                n_res.status = mlm_pkg::ST_NOTOWNER;
                                n_state = S_OUT;
                            end else if (lq.hd_v) begin
                                // fetch the head waiter for the handover
                                trd_en = t_ok(lq.head);
                                trd_a = TW'(lq.head);
                                n_state = S_HEAD;
                            end else begin
                                n_le.held = 1'b0;
                                n_le.owner = '0;
                                n_res.status = mlm_pkg::ST_RELEASED;
                            end
                        end
                        default: begin
                            if (r_kind == mlm_pkg::K_DESTROY && !lq.ready) begin
                                n_res.status = mlm_pkg::ST_UNINIT;
                                n_state = S_OUT;
                            end else if (lq.hd_v) begin
                                n_res.status = mlm_pkg::ST_INUSE;
                                n_state = S_OUT;
                            end else begin
                                n_le = '0;
                                n_le.ready = (r_kind == mlm_pkg::K_INIT);
                            end
                        end
                    endcase
                end
            end
            S_WT: begin
                // one wait-for step: test owner, fetch its thread entry
                if (r_steps == SW'(NUM_THREADS)) begin
                    do_enq = 1'b1;
                end else if (r_own == r_t) begin
                    n_res.status = mlm_pkg::ST_DEADLOCK;
                    n_state = S_OUT;
                end else if (!t_ok(r_own)) begin
                    do_enq = 1'b1;
                end else begin
                    trd_en = 1'b1;
                    trd_a = TW'(r_own);
                    n_state = S_WL;
                end
            end
            S_WL: begin
                // owner's thread entry is in tq: follow the lock it waits on
                if (!tq.wait_v || !l_ok(tq.wait_lk)) begin
                    do_enq = 1'b1;
                end else begin
                    lrd_en = 1'b1;
                    lrd_a = LW'(tq.wait_lk);
                    n_state = S_WO;
                end
            end
            S_WO: begin
                // awaited lock entry is in lq: advance to its owner
                if (!lq.held) begin
                    do_enq = 1'b1;
                end else begin
                    n_own = lq.owner;
                    n_steps = r_steps + 1'b1;
                    n_state = S_WT;
                end
            end
            S_HEAD: begin
                // pop the head waiter and make it the owner
                n_le.owner = r_le.head;
                if (t_ok(r_le.head)) begin
                    n_le.hd_v = tq.nxt_v;
                    n_le.head = tq.nxt;
                    n_twe = 1'b1;
                    n_twa = TW'(r_le.head);
                    n_twd = '0;
                end else begin
                    n_le.hd_v = 1'b0;
                    n_le.head = '0;
                end
                if (!n_le.hd_v) begin
                    n_le.tl_v = 1'b0;
                    n_le.tail = '0;
                end
                n_res = '{mlm_pkg::ST_HANDOVER, 1'b1, r_le.head};
                n_state = S_WB;
            end
            S_WB: begin
                lwr_en = 1'b1;
                twr_en = r_twe;
                n_state = r_link ? S_LINK : S_OUT;
            end
            S_LINK: begin
                // old tail gets the caller as next
                twr_en = 1'b1;
                twr_a = r_linka;
                twr_d = '{1'b1, r_lk, 1'b1, r_t};
                n_state = S_OUT;
            end
            S_OUT: begin
                if (out_load) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
        // queue the caller behind the current holder
        if (do_enq) begin
            n_link  = n_le.hd_v;
            n_linka = TW'(n_le.tail);
            n_le    = enq_ent(n_le, r_t);
            n_twe   = 1'b1;
            n_twa   = TW'(r_t);
            n_twd   = '{1'b1, r_lk, 1'b0, '0};
            n_res.status = mlm_pkg::ST_QUEUED;
            n_state = S_WB;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ec <= 1'b1;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) r_ec <= i_cfg_wdata;
            if (out_load) r_ovalid <= 1'b1;
            else if (o_rsp.ready) r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && i_req.valid) begin
            r_kind <= i_req.kind;
            r_t    <= i_req.caller;
            r_lk   <= i_req.lock_id;
            r_oor  <= !t_ok(i_req.caller) || !l_ok(i_req.lock_id);
        end
        r_le <= n_le;
        r_own <= n_own;
        r_steps <= n_steps;
        r_twe <= n_twe;
        r_twa <= n_twa;
        r_twd <= n_twd;
        r_link <= n_link;
        r_linka <= n_linka;
        r_res <= n_res;
        if (out_load) r_out <= r_res;
    end

    // Only one request in flight.
    a_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_req.valid && i_req.ready) |=> !i_req.ready)
        else $error("second request accepted while busy");
    a_walk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WT) |-> (r_steps <= SW'(NUM_THREADS)))
        else $error("wait-for walk overran");
    a_wb: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WB) |=> (r_state == S_OUT || r_state == S_LINK))
        else $error("write-back not followed by link or result");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ovalid && !o_rsp.ready) |=> (r_ovalid && $stable(r_out)))
        else $error("pending result changed or dropped");
    a_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot(r_state))
        else $error("state register not one-hot");
endmodule

// ===== tb/mlm_lock_checker.sv =====
// Checker for the mutex lock manager: tracks lock and thread tables, predicts the
// result of every request transfer and compares it with the result transfers.
// Depends on mlm_pkg and the channel interfaces in mlm_if.sv.
module mlm_lock_checker #(
    parameter int NUM_THREADS = 16,
    parameter int NUM_LOCKS   = 16
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic       i_cfg_wdata,
    mlm_req_if         i_req,
    mlm_rsp_if         i_rsp,
    output int         o_fail_count,
    output int         o_pending
);
    localparam int ID_W   = mlm_pkg::ID_W;
    localparam int KIND_W = mlm_pkg::KIND_W;

    logic              chk_en;
    logic              ready_q  [NUM_LOCKS];
    logic              held_q   [NUM_LOCKS];
    logic [ID_W-1:0]   owner_q  [NUM_LOCKS];
    logic              hd_v_q   [NUM_LOCKS];
    logic [ID_W-1:0]   head_q   [NUM_LOCKS];
    logic [ID_W-1:0]   tail_q   [NUM_LOCKS];
    logic              wait_v_q [NUM_THREADS];
    logic [ID_W-1:0]   wait_lk_q[NUM_THREADS];
    logic              nxt_v_q  [NUM_THREADS];
    logic [ID_W-1:0]   nxt_q    [NUM_THREADS];
    mlm_pkg::t_result  status_fifo[$];

    // Follow owner -> awaited lock -> owner, bounded by the thread count.
    function automatic logic cycle_found(input logic [ID_W-1:0] lk,
                                         input logic [ID_W-1:0] thr);
        logic [ID_W-1:0] own;
        logic [ID_W-1:0] m;
        own = owner_q[lk];
        for (int s = 0; s < NUM_THREADS; s++) begin
            if (own == thr) return 1'b1;
            if (int'(own) >= NUM_THREADS) return 1'b0;
            if (!wait_v_q[own]) return 1'b0;
            m = wait_lk_q[own];
            if (int'(m) >= NUM_LOCKS || !held_q[m]) return 1'b0;
            own = owner_q[m];
        end
        return 1'b0;
    endfunction

    function automatic mlm_pkg::t_result lock_step(input logic [KIND_W-1:0] kind,
                                                   input logic [ID_W-1:0] thr,
                                                   input logic [ID_W-1:0] lk);
        mlm_pkg::t_result r;
        logic [ID_W-1:0] h;
        r = '0;
        if (int'(thr) >= NUM_THREADS || int'(lk) >= NUM_LOCKS) begin
            r.status = mlm_pkg::ST_UNINIT;
        end else if (wait_v_q[thr]) begin
            r.status = mlm_pkg::ST_WAITING;
        end else if (kind == mlm_pkg::K_LOCK) begin
            if (!ready_q[lk]) begin
                r.status = mlm_pkg::ST_UNINIT;
            end else if (!held_q[lk]) begin
                held_q[lk] = 1'b1;
                owner_q[lk] = thr;
                r.status = mlm_pkg::ST_GRANTED;
            end else if (chk_en && cycle_found(lk, thr)) begin
                r.status = mlm_pkg::ST_DEADLOCK;
            end else begin
                wait_v_q[thr] = 1'b1;
                wait_lk_q[thr] = lk;
                nxt_v_q[thr] = 1'b0;
                nxt_q[thr] = '0;
                if (hd_v_q[lk]) begin
                    nxt_v_q[tail_q[lk]] = 1'b1;
                    nxt_q[tail_q[lk]] = thr;
                end else begin
                    hd_v_q[lk] = 1'b1;
                    head_q[lk] = thr;
                end
                tail_q[lk] = thr;
                r.status = mlm_pkg::ST_QUEUED;
            end
        end else if (kind == mlm_pkg::K_UNLOCK) begin
            if (!ready_q[lk]) begin
                r.status = mlm_pkg::ST_UNINIT;
            end else if (!held_q[lk] || owner_q[lk] != thr) begin
                r.status = mlm_pkg::ST_NOTOWNER;
            end else if (hd_v_q[lk]) begin
                h = head_q[lk];
                hd_v_q[lk] = nxt_v_q[h];
                head_q[lk] = nxt_q[h];
                nxt_v_q[h] = 1'b0;
                nxt_q[h] = '0;
                wait_v_q[h] = 1'b0;
                owner_q[lk] = h;
                r.status = mlm_pkg::ST_HANDOVER;
                r.woken_valid = 1'b1;
                r.woken_thread = h;
            end else begin
                held_q[lk] = 1'b0;
                owner_q[lk] = '0;
                r.status = mlm_pkg::ST_RELEASED;
            end
        end else begin
            if (kind == mlm_pkg::K_DESTROY && !ready_q[lk]) begin
                r.status = mlm_pkg::ST_UNINIT;
            end else if (hd_v_q[lk]) begin
                r.status = mlm_pkg::ST_INUSE;
            end else begin
                ready_q[lk] = (kind == mlm_pkg::K_INIT);
                held_q[lk] = 1'b0;
                owner_q[lk] = '0;
                hd_v_q[lk] = 1'b0;
                r.status = mlm_pkg::ST_GRANTED;
            end
        end
        return r;
    endfunction

    always @(posedge i_clk) begin
        mlm_pkg::t_result got;
        mlm_pkg::t_result want;
        if (!i_rst_n) begin
            chk_en <= 1'b1;
            o_fail_count <= 0;
            o_pending <= 0;
            status_fifo.delete();
            for (int i = 0; i < NUM_LOCKS; i++) begin
                ready_q[i] = 1'b0; held_q[i] = 1'b0; owner_q[i] = '0;
                hd_v_q[i] = 1'b0; head_q[i] = '0; tail_q[i] = '0;
            end
            for (int i = 0; i < NUM_THREADS; i++) begin
                wait_v_q[i] = 1'b0; wait_lk_q[i] = '0;
                nxt_v_q[i] = 1'b0; nxt_q[i] = '0;
            end
        end else begin
            // Check results first: a result never answers a same-edge request.
            if (i_rsp.valid && i_rsp.ready) begin
                got = '{i_rsp.status, i_rsp.woken_valid, i_rsp.woken_thread};
                if (status_fifo.size() == 0) begin
                    $display("%0t: unexpected result, actual %p", $time, got);
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    want = status_fifo.pop_front();
                    if (got.status !== want.status ||
                        got.woken_valid !== want.woken_valid ||
                        got.woken_thread !== want.woken_thread) begin
                        $display("%0t: mismatch, expected %p actual %p",
                                 $time, want, got);
                        o_fail_count <= o_fail_count + 1;
                    end
                end
            end
            if (i_req.valid && i_req.ready)
                status_fifo.push_back(lock_step(i_req.kind, i_req.caller,
                                                i_req.lock_id));
            o_pending <= status_fifo.size();
            if (i_cfg_we) chk_en <= i_cfg_wdata;
        end
    end
endmodule

// ===== tb/tb_mutex_lock_manager_deadlock_check.sv =====
// Top of the lock manager testbench: clock, reset, request stimulus, result
// back-pressure and the verdict. Depends on mlm_pkg, mlm_if.sv, mlm_lock_checker.
module tb_mutex_lock_manager_deadlock_check;
    localparam int ID_W   = mlm_pkg::ID_W;
    localparam int KIND_W = mlm_pkg::KIND_W;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int DRAIN_CYCLES   = 60;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_cfg_we = 1'b0;
    logic i_cfg_wdata = 1'b0;
    int   fail_count;
    int   pending;
    int   idle_cycles;

    mlm_req_if req_ch();
    mlm_rsp_if rsp_ch();

    mutex_lock_manager_deadlock_check uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cfg_we(i_cfg_we),
        .i_cfg_wdata(i_cfg_wdata), .i_req(req_ch.sink), .o_rsp(rsp_ch.source)
    );

    mlm_lock_checker checker_i (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cfg_we(i_cfg_we),
        .i_cfg_wdata(i_cfg_wdata), .i_req(req_ch), .i_rsp(rsp_ch),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Mostly short gaps, now and then a long one.
    function automatic int gap_len();
        int p;
        p = $urandom_range(0, 99);
        if (p < 45) return 0;
        if (p < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Result side: stall at random; run stretches with ready held high.
    logic stall_free = 1'b0;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            rsp_ch.ready <= 1'b0;
        end else begin
            if ($urandom_range(0, 199) == 0) stall_free <= ~stall_free;
            rsp_ch.ready <= stall_free ? 1'b1 : (gap_len() == 0);
        end
    end

    // Watchdog: count cycles with no transfer on either channel.
    always @(posedge i_clk) begin
        if (!i_rst_n || (req_ch.valid && req_ch.ready) ||
            (rsp_ch.valid && rsp_ch.ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("CHECKS FAILED");
                $finish;
            end
        end
    end

    // Present one request and hold it until the transfer; valid stays up and is
    // dropped by the gap of the next call, unless that gap is empty (back-to-back).
    task automatic send_req(input logic [KIND_W-1:0] kind,
                            input logic [ID_W-1:0] thr,
                            input logic [ID_W-1:0] lk);
        int g;
        g = gap_len();
        repeat (g) begin
            req_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        req_ch.valid <= 1'b1;
        req_ch.kind <= kind;
        req_ch.caller <= thr;
        req_ch.lock_id <= lk;
        @(posedge i_clk);
        while (!req_ch.ready) @(posedge i_clk);
    endtask

    // Hold off until every result is back, then let the block settle.
    task automatic drain();
        req_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_check_enable(input logic en);
        drain();
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= en;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // Random request: lock-heavy traffic on a few threads and locks so
    // queues, handovers and wait-for cycles actually build up.
    task automatic random_req();
        int p;
        logic [KIND_W-1:0] k;
        logic [ID_W-1:0] t;
        logic [ID_W-1:0] l;
        p = $urandom_range(0, 99);
        if (p < 45) k = mlm_pkg::K_LOCK;
        else if (p < 85) k = mlm_pkg::K_UNLOCK;
        else if (p < 93) k = mlm_pkg::K_INIT;
        else k = mlm_pkg::K_DESTROY;
        if ($urandom_range(0, 9) < 8) begin
            t = ID_W'($urandom_range(0, 5));
            l = ID_W'($urandom_range(0, 3));
        end else begin
            t = ID_W'($urandom_range(0, 15));
            l = ID_W'($urandom_range(0, 15));
        end
        send_req(k, t, l);
    endtask

    initial begin
        req_ch.valid <= 1'b0;
        req_ch.kind <= mlm_pkg::K_LOCK;
        req_ch.caller <= '0;
        req_ch.lock_id <= '0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: uninitialized, init, grant, self-deadlock, queue,
        // two-thread cycle, handover, not owner, in use, already waiting.
        send_req(mlm_pkg::K_LOCK, 4'd0, 4'd0);
        send_req(mlm_pkg::K_DESTROY, 4'd0, 4'd0);
        send_req(mlm_pkg::K_UNLOCK, 4'd0, 4'd0);
        send_req(mlm_pkg::K_INIT, 4'd15, 4'd0);
        send_req(mlm_pkg::K_INIT, 4'd15, 4'd15);
        send_req(mlm_pkg::K_LOCK, 4'd0, 4'd0);
        send_req(mlm_pkg::K_LOCK, 4'd0, 4'd0);
        send_req(mlm_pkg::K_LOCK, 4'd15, 4'd15);
        send_req(mlm_pkg::K_LOCK, 4'd15, 4'd0);
        send_req(mlm_pkg::K_LOCK, 4'd0, 4'd15);
        send_req(mlm_pkg::K_LOCK, 4'd15, 4'd15);
        send_req(mlm_pkg::K_UNLOCK, 4'd5, 4'd0);
        send_req(mlm_pkg::K_INIT, 4'd1, 4'd0);
        send_req(mlm_pkg::K_DESTROY, 4'd1, 4'd0);
        send_req(mlm_pkg::K_UNLOCK, 4'd0, 4'd0);
        send_req(mlm_pkg::K_UNLOCK, 4'd15, 4'd0);
        send_req(mlm_pkg::K_UNLOCK, 4'd15, 4'd0);
        send_req(mlm_pkg::K_DESTROY, 4'd15, 4'd15);

        // Error checking off: queue a thread behind itself; its later requests find it waiting.
        write_check_enable(1'b0);
        send_req(mlm_pkg::K_INIT, 4'd3, 4'd7);
        send_req(mlm_pkg::K_LOCK, 4'd3, 4'd7);
        send_req(mlm_pkg::K_LOCK, 4'd3, 4'd7);
        send_req(mlm_pkg::K_UNLOCK, 4'd3, 4'd7);
        send_req(mlm_pkg::K_UNLOCK, 4'd3, 4'd7);
        send_req(mlm_pkg::K_DESTROY, 4'd3, 4'd7);
        write_check_enable(1'b1);

        for (int i = 0; i < 600; i++) begin
            if (i == 200) write_check_enable(1'b0);
            if (i == 350) write_check_enable(1'b1);
            random_req();
        end

        drain();
        if (fail_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end
endmodule
